[hw/rtl/int32_alu_fold_with_poison_defines.svh]
// Assertion macros shared by the checker of the folding ALU.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef INT32_ALU_FOLD_WITH_POISON_DEFINES_SVH
`define INT32_ALU_FOLD_WITH_POISON_DEFINES_SVH

// Concurrent assertion clocked on clk, held off while reset is asserted.
`define IALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that only starts to check once the cycle before was out of reset too.
`define IALU_ASSERT_SETTLED(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> (prop)) \
        else $error(msg);

`endif

[hw/rtl/ialu_pkg.sv]
// Shared types and constants for the 32-bit folding ALU.
// Depends on nothing; used by every module of the block but the checker.
`timescale 1ns / 1ps

package ialu_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = WORD_W;
    localparam logic [WORD_W-1:0] INT_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_AND  = 5'd3,
        OP_OR   = 5'd4,
        OP_XOR  = 5'd5,
        OP_SHL  = 5'd6,
        OP_LSHR = 5'd7,
        OP_ASHR = 5'd8,
        OP_UDIV = 5'd9,
        OP_SDIV = 5'd10,
        OP_UREM = 5'd11,
        OP_SREM = 5'd12,
        OP_EQ   = 5'd13,
        OP_NE   = 5'd14,
        OP_ULT  = 5'd15,
        OP_ULE  = 5'd16,
        OP_UGT  = 5'd17,
        OP_UGE  = 5'd18,
        OP_SLT  = 5'd19,
        OP_SLE  = 5'd20,
        OP_SGT  = 5'd21,
        OP_SGE  = 5'd22
    } action_t;

    // One operation in flight through the divider chain.
    typedef struct packed {
        logic              known;
        logic              is_div;
        logic              sel_rem;
        logic              neg_q;
        logic              neg_r;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] dq;
        logic [WORD_W-1:0] dvs;
    } item_t;

endpackage

[hw/rtl/ialu_front.sv]
// Two front stages: operand capture with products, then folding of all non-divide ops and divide set-up.
// Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ialu_pkg::action_t          action,
    input  logic [ialu_pkg::WORD_W-1:0] left_value,
    input  logic                       left_known,
    input  logic [ialu_pkg::WORD_W-1:0] right_value,
    input  logic                       right_known,
    input  logic                       no_unsigned_wrap,
    input  logic                       no_signed_wrap,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ialu_pkg::item_t            out_item
);

    localparam int W = ialu_pkg::WORD_W;

    // Stage A registers.
    logic                a_valid_reg;
    ialu_pkg::action_t   a_op_reg;
    logic [W-1:0]        a_x_reg;
    logic [W-1:0]        a_y_reg;
    logic                a_known_reg;
    logic                a_nuw_reg;
    logic                a_nsw_reg;
    logic [2*W-1:0]      a_uprod_reg;
    logic [2*W+1:0]      a_sprod_reg;
    logic                a_ready;

    // Stage B registers.
    logic                b_valid_reg;
    ialu_pkg::item_t     b_item_reg;
    ialu_pkg::item_t     b_item_next;

    logic [W:0]          sum;
    logic [W-1:0]        diff;
    logic [W-1:0]        ax;
    logic [W-1:0]        ay;
    logic                uover;
    logic                sover;
    logic                arith;
    logic                ok;
    logic [W-1:0]        value;
    logic                bad_shift;
    logic                dz;
    logic                sdiv_ovf;
    logic [4:0]          shamt;

    assign in_ready = !a_valid_reg || a_ready;
    assign a_ready  = !b_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_op_reg    <= action;
            a_x_reg     <= left_value;
            a_y_reg     <= right_value;
            a_known_reg <= left_known && right_known;
            a_nuw_reg   <= no_unsigned_wrap;
            a_nsw_reg   <= no_signed_wrap;
            a_uprod_reg <= {{W{1'b0}}, left_value} * {{W{1'b0}}, right_value};
            a_sprod_reg <= $signed({{(W+2){left_value[W-1]}}, left_value})
                         * $signed({{(W+2){right_value[W-1]}}, right_value});
        end
        if (a_valid_reg && a_ready)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign sum       = {1'b0, a_x_reg} + {1'b0, a_y_reg};
    assign diff      = a_x_reg - a_y_reg;
    assign bad_shift = |a_y_reg[W-1:5];
    assign shamt     = a_y_reg[4:0];
    assign dz        = (a_y_reg == '0);
    assign sdiv_ovf  = (a_x_reg == ialu_pkg::INT_MIN) && (a_y_reg == ialu_pkg::ALL_ONES);
    assign ax        = a_x_reg[W-1] ? -a_x_reg : a_x_reg;
    assign ay        = a_y_reg[W-1] ? -a_y_reg : a_y_reg;

    always_comb
    begin
        ok          = a_known_reg;
        value       = '0;
        uover       = 1'b0;
        sover       = 1'b0;
        arith       = 1'b0;
        b_item_next = '0;
        unique case (a_op_reg) inside
            ialu_pkg::OP_ADD:
            begin
                value = sum[W-1:0];
                uover = sum[W];
                sover = (a_x_reg[W-1] == a_y_reg[W-1]) && (sum[W-1] != a_x_reg[W-1]);
                arith = 1'b1;
            end
            ialu_pkg::OP_SUB:
            begin
                value = diff;
                uover = a_y_reg > a_x_reg;
                sover = (a_x_reg[W-1] != a_y_reg[W-1]) && (diff[W-1] != a_x_reg[W-1]);
                arith = 1'b1;
            end
            ialu_pkg::OP_MUL:
            begin
                value = a_uprod_reg[W-1:0];
                uover = |a_uprod_reg[2*W-1:W];
                sover = (a_sprod_reg[2*W+1:W-1] != '0) && (a_sprod_reg[2*W+1:W-1] != '1);
                arith = 1'b1;
            end
            ialu_pkg::OP_AND:  value = a_x_reg & a_y_reg;
            ialu_pkg::OP_OR:   value = a_x_reg | a_y_reg;
            ialu_pkg::OP_XOR:  value = a_x_reg ^ a_y_reg;
            ialu_pkg::OP_SHL:
            begin
                value = a_x_reg << shamt;
                ok    = ok && !bad_shift;
            end
            ialu_pkg::OP_LSHR:
            begin
                value = a_x_reg >> shamt;
                ok    = ok && !bad_shift;
            end
            ialu_pkg::OP_ASHR:
            begin
                value = $unsigned($signed(a_x_reg) >>> shamt);
                ok    = ok && !bad_shift;
            end
            ialu_pkg::OP_UDIV, ialu_pkg::OP_UREM:
            begin
                ok                 = ok && !dz;
                b_item_next.is_div = 1'b1;
                b_item_next.dq     = a_x_reg;
                b_item_next.dvs    = a_y_reg;
            end
            ialu_pkg::OP_SDIV, ialu_pkg::OP_SREM:
            begin
                ok                 = ok && !dz && !sdiv_ovf;
                b_item_next.is_div = 1'b1;
                b_item_next.dq     = ax;
                b_item_next.dvs    = ay;
                b_item_next.neg_q  = a_x_reg[W-1] ^ a_y_reg[W-1];
                b_item_next.neg_r  = a_x_reg[W-1];
            end
            ialu_pkg::OP_EQ:   value = W'(a_x_reg == a_y_reg);
            ialu_pkg::OP_NE:   value = W'(a_x_reg != a_y_reg);
            ialu_pkg::OP_ULT:  value = W'(a_x_reg <  a_y_reg);
            ialu_pkg::OP_ULE:  value = W'(a_x_reg <= a_y_reg);
            ialu_pkg::OP_UGT:  value = W'(a_x_reg >  a_y_reg);
            ialu_pkg::OP_UGE:  value = W'(a_x_reg >= a_y_reg);
            ialu_pkg::OP_SLT:  value = W'($signed(a_x_reg) <  $signed(a_y_reg));
            ialu_pkg::OP_SLE:  value = W'($signed(a_x_reg) <= $signed(a_y_reg));
            ialu_pkg::OP_SGT:  value = W'($signed(a_x_reg) >  $signed(a_y_reg));
            ialu_pkg::OP_SGE:  value = W'($signed(a_x_reg) >= $signed(a_y_reg));
            default:           ok = 1'b0;
        endcase
        if (arith && ((a_nuw_reg && uover) || (a_nsw_reg && sover)))
        begin
            ok = 1'b0;
        end
        b_item_next.known   = ok;
        b_item_next.value   = value;
        b_item_next.sel_rem = (a_op_reg == ialu_pkg::OP_UREM) || (a_op_reg == ialu_pkg::OP_SREM);
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

[hw/rtl/ialu_div_cell.sv]
// One cell of the divider chain: one restoring quotient bit, then hand-off to the next cell.
// Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ialu_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output ialu_pkg::item_t out_item
);

    localparam int W = ialu_pkg::WORD_W;

    logic            valid_reg;
    ialu_pkg::item_t item_reg;
    ialu_pkg::item_t item_next;
    logic [W:0]      trial;
    logic [W:0]      delta;
    logic            fits;

    assign in_ready = !valid_reg || out_ready;

    assign trial = {in_item.rem, in_item.dq[W-1]};
    assign delta = trial - {1'b0, in_item.dvs};
    assign fits  = !delta[W];

    always_comb
    begin
        item_next     = in_item;
        item_next.rem = fits ? delta[W-1:0] : trial[W-1:0];
        item_next.dq  = {in_item.dq[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hw/rtl/ialu_back.sv]
// Output stage: sign fix of quotient or remainder, zeroing of unknown results, output register.
// Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ialu_pkg::item_t             in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ialu_pkg::WORD_W-1:0] result_value,
    output logic                        result_known
);

    localparam int W = ialu_pkg::WORD_W;

    logic         valid_reg;
    logic [W-1:0] value_reg;
    logic         known_reg;
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    logic [W-1:0] value_next;

    assign in_ready = !valid_reg || out_ready;

    assign quo = in_item.neg_q ? -in_item.dq : in_item.dq;
    assign rem = in_item.neg_r ? -in_item.rem : in_item.rem;

    always_comb
    begin
        value_next = in_item.value;
        if (in_item.is_div)
        begin
            value_next = in_item.sel_rem ? rem : quo;
        end
        if (!in_item.known)
        begin
            value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            value_reg <= value_next;
            known_reg <= in_item.known;
        end
    end

    assign out_valid    = valid_reg;
    assign result_value = value_reg;
    assign result_known = known_reg;

endmodule

[hw/rtl/int32_alu_fold_with_poison.sv]
// Top level of the 32-bit folding ALU with known/unknown operand tags.
// Depends on ialu_pkg, ialu_front, ialu_div_cell and ialu_back.
`timescale 1ns / 1ps

// Usage:
// One operation enters on the s_axis group as a single transaction and leaves one
// transaction on the m_axis group carrying the folded value and its known flag.
// Every operation, divide or not, walks the same path: two front stages (operand
// capture with both products, then folding of every non-divide operation), a
// chain of 32 divider cells that each settle one quotient bit, and one output
// register that fixes signs and zeroes unknown results.
// Throughput is one transaction per cycle while the receiver does not stall;
// the divider chain, one cell per quotient bit, sets the depth.
// Each stage holds its item until the next one frees up, so bubbles close up and
// the input keeps being taken while a finished result waits on the output.
// When the receiver stalls, the output register holds its data steady and the
// stall moves back stage by stage; s_axis_tready drops only when every stage is full.
// Reset empties all stages; nothing else is stored, so no clearing is needed.
module int32_alu_fold_with_poison (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] action, [36:5] left_value, [37] left_known, [69:38] right_value,
    // [70] right_known, [71] no_unsigned_wrap, [72] no_signed_wrap, [79:73] zero
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result_value, [32] result_known, [39:33] zero
    output logic [39:0] m_axis_tdata
);

    localparam int N = ialu_pkg::DIV_STEPS;

    logic                        chain_valid [N+1];
    logic                        chain_ready [N+1];
    ialu_pkg::item_t             chain_item  [N+1];
    logic [ialu_pkg::WORD_W-1:0] result_value;
    logic                        result_known;

    ialu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .action           (ialu_pkg::action_t'(s_axis_tdata[4:0])),
        .left_value       (s_axis_tdata[36:5]),
        .left_known       (s_axis_tdata[37]),
        .right_value      (s_axis_tdata[69:38]),
        .right_known      (s_axis_tdata[70]),
        .no_unsigned_wrap (s_axis_tdata[71]),
        .no_signed_wrap   (s_axis_tdata[72]),
        .out_valid        (chain_valid[0]),
        .out_ready        (chain_ready[0]),
        .out_item         (chain_item[0])
    );

    // The divider chain: each cell shifts one dividend bit into the partial remainder.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        ialu_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    ialu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[N]),
        .in_ready     (chain_ready[N]),
        .in_item      (chain_item[N]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .result_value (result_value),
        .result_known (result_known)
    );

    assign m_axis_tdata = {7'd0, result_known, result_value};

endmodule

[hw/rtl/ialu_checker.sv]
// Port-level checker for the folding ALU, bound to the top level.
// Depends on int32_alu_fold_with_poison_defines.svh.
`timescale 1ns / 1ps
`include "int32_alu_fold_with_poison_defines.svh"

module ialu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A stalled result transaction keeps its data.
    `IALU_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // An unknown result always carries a zero value.
    `IALU_ASSERT(a_unknown_zero, m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0, "unknown result with nonzero value")

    // Padding bits of the result stay zero.
    `IALU_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0, "nonzero padding on output")

    // With the output draining, the input side is never blocked.
    `IALU_ASSERT_SETTLED(a_drain_ready, m_axis_tready |-> s_axis_tready, "input blocked while output drains")

endmodule

bind int32_alu_fold_with_poison ialu_checker u_ialu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/tb_int32_alu_fold_with_poison.sv]
// Testbench for the 32-bit folding ALU: directed corner operations, then random traffic.
// Depends on ialu_pkg and int32_alu_fold_with_poison; results are checked by a scoreboard.
`timescale 1ns / 1ps

module tb_int32_alu_fold_with_poison;

    typedef struct packed {
        logic        nsw;
        logic        nuw;
        logic        rk;
        logic [31:0] rv;
        logic        lk;
        logic [31:0] lv;
        logic [4:0]  act;
    } fold_op_t;

    // Holds the predicted folded results in order and compares arriving ones.
    class fold_scoreboard;
        logic [32:0] pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Computes the folded value of one operation; bit 32 is the known flag.
        function logic [32:0] fold(fold_op_t op);
            logic [63:0]  wide;
            logic signed [63:0] sx;
            logic signed [63:0] sy;
            logic signed [63:0] sres;
            logic [31:0]  val;
            logic         ok;
            logic         uov;
            logic         sov;
            logic         arith;
            sx = $signed(op.lv);
            sy = $signed(op.rv);
            val = '0;
            ok = op.lk && op.rk;
            uov = 1'b0;
            sov = 1'b0;
            arith = 1'b0;
            sres = 0;
            if (ok)
            begin
                case (op.act) inside
                    ialu_pkg::OP_ADD:
                    begin
                        wide = {32'd0, op.lv} + {32'd0, op.rv};
                        val = wide[31:0];
                        uov = wide[32];
                        sres = sx + sy;
                        arith = 1'b1;
                    end
                    ialu_pkg::OP_SUB:
                    begin
                        val = op.lv - op.rv;
                        uov = op.rv > op.lv;
                        sres = sx - sy;
                        arith = 1'b1;
                    end
                    ialu_pkg::OP_MUL:
                    begin
                        wide = {32'd0, op.lv} * {32'd0, op.rv};
                        val = wide[31:0];
                        uov = wide[63:32] != 0;
                        sres = sx * sy;
                        arith = 1'b1;
                    end
                    ialu_pkg::OP_AND: val = op.lv & op.rv;
                    ialu_pkg::OP_OR:  val = op.lv | op.rv;
                    ialu_pkg::OP_XOR: val = op.lv ^ op.rv;
                    ialu_pkg::OP_SHL, ialu_pkg::OP_LSHR, ialu_pkg::OP_ASHR:
                    begin
                        if (op.rv >= 32)
                            ok = 1'b0;
                        else if (op.act == ialu_pkg::OP_SHL)
                            val = op.lv << op.rv[4:0];
                        else if (op.act == ialu_pkg::OP_LSHR)
                            val = op.lv >> op.rv[4:0];
                        else
                            val = $signed(op.lv) >>> op.rv[4:0];
                    end
                    ialu_pkg::OP_UDIV, ialu_pkg::OP_UREM:
                    begin
                        if (op.rv == 0)
                            ok = 1'b0;
                        else
                            val = (op.act == ialu_pkg::OP_UDIV) ? op.lv / op.rv
                                                                : op.lv % op.rv;
                    end
                    ialu_pkg::OP_SDIV, ialu_pkg::OP_SREM:
                    begin
                        if (op.rv == 0 || (op.lv == ialu_pkg::INT_MIN
                                           && op.rv == ialu_pkg::ALL_ONES))
                            ok = 1'b0;
                        else
                        begin
                            sres = (op.act == ialu_pkg::OP_SDIV) ? sx / sy : sx % sy;
                            val = sres[31:0];
                        end
                    end
                    ialu_pkg::OP_EQ:  val = 32'(op.lv == op.rv);
                    ialu_pkg::OP_NE:  val = 32'(op.lv != op.rv);
                    ialu_pkg::OP_ULT: val = 32'(op.lv < op.rv);
                    ialu_pkg::OP_ULE: val = 32'(op.lv <= op.rv);
                    ialu_pkg::OP_UGT: val = 32'(op.lv > op.rv);
                    ialu_pkg::OP_UGE: val = 32'(op.lv >= op.rv);
                    ialu_pkg::OP_SLT: val = 32'(sx < sy);
                    ialu_pkg::OP_SLE: val = 32'(sx <= sy);
                    ialu_pkg::OP_SGT: val = 32'(sx > sy);
                    ialu_pkg::OP_SGE: val = 32'(sx >= sy);
                    default: ok = 1'b0;
                endcase
            end
            if (arith)
            begin
                sov = (sres < -64'sd2147483648) || (sres > 64'sd2147483647);
                if ((op.nuw && uov) || (op.nsw && sov))
                    ok = 1'b0;
            end
            if (!ok)
                val = '0;
            return {ok, val};
        endfunction

        function void note_operation(fold_op_t op);
            pending.insert(pending.size(), fold(op));
        endfunction

        function void check_result(logic [39:0] data);
            logic [32:0] exp_res;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction %h", data);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (data[31:0] !== exp_res[31:0])
            begin
                $error("result_value expected %h actual %h", exp_res[31:0], data[31:0]);
                errors++;
            end
            if (data[32] !== exp_res[32])
            begin
                $error("result_known expected %b actual %b", exp_res[32], data[32]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    fold_scoreboard sb = new();
    bit sink_calm = 1'b0;      // no receiver stalls during the final stretch
    bit long_hold = 1'b0;      // request for one long receiver hold-off

    always #6 clk = ~clk;

    int32_alu_fold_with_poison DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Result acceptance is judged at the rising edge, where the handshake happens.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Receiver: random stall bursts, one long hold-off on request, calm at the end.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (120) @(negedge clk);
                long_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!sink_calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 17);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one operation from a falling edge and returns at the falling edge after
    // it is taken, with tvalid still high so the next transaction can follow at once.
    task automatic send_op(fold_op_t op);
        s_axis_tdata <= {7'd0, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_operation(op);
        @(negedge clk);
    endtask

    // Sender gap of a random burst length, or none.
    task automatic maybe_gap(bit allow);
        if (allow && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return ialu_pkg::ALL_ONES;
            2: return ialu_pkg::INT_MIN;
            3: return ialu_pkg::INT_MIN - 1;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic fold_op_t make_op(logic [4:0] act, logic [31:0] a, logic [31:0] b,
                                         logic lk, logic rk, logic nuw, logic nsw);
        fold_op_t op;
        op.act = act;
        op.lv = a;
        op.rv = b;
        op.lk = lk;
        op.rk = rk;
        op.nuw = nuw;
        op.nsw = nsw;
        return op;
    endfunction

    // Lets the pipeline drain completely while the sender stays silent.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        fold_op_t op;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: unknown operands, oversized shifts, division by zero,
        // signed division overflow, wrap flags, undefined selectors.
        send_op(make_op(ialu_pkg::OP_ADD, 32'd5, 32'd7, 1'b0, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_ADD, 32'd5, 32'd7, 1'b1, 1'b0, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_ADD, ialu_pkg::ALL_ONES, 32'd1,
                        1'b1, 1'b1, 1'b1, 1'b0));
        send_op(make_op(ialu_pkg::OP_ADD, ialu_pkg::ALL_ONES, 32'd1,
                        1'b1, 1'b1, 1'b0, 1'b1));
        send_op(make_op(ialu_pkg::OP_ADD, ialu_pkg::INT_MIN - 1, 32'd1,
                        1'b1, 1'b1, 1'b0, 1'b1));
        send_op(make_op(ialu_pkg::OP_SUB, 32'd0, 32'd1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_op(make_op(ialu_pkg::OP_SUB, ialu_pkg::INT_MIN, 32'd1,
                        1'b1, 1'b1, 1'b0, 1'b1));
        send_op(make_op(ialu_pkg::OP_MUL, 32'h10000, 32'h10000, 1'b1, 1'b1, 1'b1, 1'b0));
        send_op(make_op(ialu_pkg::OP_MUL, ialu_pkg::INT_MIN, ialu_pkg::ALL_ONES,
                        1'b1, 1'b1, 1'b0, 1'b1));
        send_op(make_op(ialu_pkg::OP_SHL, 32'd1, 32'd31, 1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_SHL, 32'd1, 32'd32, 1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_LSHR, ialu_pkg::ALL_ONES, ialu_pkg::ALL_ONES,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_ASHR, ialu_pkg::INT_MIN, 32'd31,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_ASHR, ialu_pkg::INT_MIN, 32'd0,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_UDIV, ialu_pkg::ALL_ONES, 32'd0,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_UREM, ialu_pkg::ALL_ONES, 32'd7,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_SDIV, ialu_pkg::INT_MIN, ialu_pkg::ALL_ONES,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_SREM, ialu_pkg::INT_MIN, ialu_pkg::ALL_ONES,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_SDIV, -32'sd7, 32'd2, 1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_SREM, -32'sd7, 32'd2, 1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_SLT, ialu_pkg::INT_MIN, 32'd0,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(ialu_pkg::OP_UGT, ialu_pkg::INT_MIN, 32'd0,
                        1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(5'd23, 32'd1, 32'd1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_op(make_op(5'd31, ialu_pkg::ALL_ONES, ialu_pkg::ALL_ONES,
                        1'b1, 1'b1, 1'b1, 1'b1));

        // Every operation once with random operands.
        for (int a = 0; a <= ialu_pkg::OP_SGE; a++)
            send_op(make_op(5'(a), pick_word(), pick_word(), 1'b1, 1'b1, 1'b0, 1'b0));

        // The sender pauses until the pipeline has delivered everything.
        wait_drained();

        // Random traffic; a long receiver hold-off lands at operation 400 so the stages
        // fill and the input stalls while operations keep being offered.
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 400)
                long_hold = 1'b1;
            if (i == 1200)
                sink_calm = 1'b1;
            op.act = ($urandom_range(0, 29) == 0) ? 5'($urandom_range(23, 31))
                                                  : 5'($urandom_range(0, 22));
            op.lv = pick_word();
            op.rv = (op.act inside {ialu_pkg::OP_SHL, ialu_pkg::OP_LSHR, ialu_pkg::OP_ASHR}
                     && $urandom_range(0, 3) != 0)
                    ? 32'($urandom_range(0, 33)) : pick_word();
            op.lk = $urandom_range(0, 11) != 0;
            op.rk = $urandom_range(0, 11) != 0;
            op.nuw = 1'($urandom_range(0, 1));
            op.nsw = 1'($urandom_range(0, 1));
            send_op(op);
            maybe_gap(!sink_calm);
        end

        wait_drained();
        repeat (40) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run guard, far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ialu_pkg.sv
hw/rtl/ialu_front.sv
hw/rtl/ialu_div_cell.sv
hw/rtl/ialu_back.sv
hw/rtl/int32_alu_fold_with_poison.sv
hw/rtl/ialu_checker.sv
test/tb_int32_alu_fold_with_poison.sv
